// ===== rtl/gfm_pkg.sv =====
// Shared types and constants for the gradient field magnitude evaluator.
// No dependencies; imported by every other file of the block.
`default_nettype none

package gfm_pkg;

  localparam int POS_W       = 32;   // position field width
  localparam int REG_W       = 48;   // config registers and most result fields
  localparam int MAG_W       = 47;   // magnitude result width
  localparam int CM_W        = 56;   // magnitude of one field component
  localparam int C_W         = 57;   // signed field component before saturation
  localparam int SQ_W        = 112;  // square of one component
  localparam int RAD_W       = 114;  // sum of squares, even width for the root
  localparam int ROOT_W      = 57;
  localparam int SQRT_STAGES = 57;   // one root bit per stage
  localparam int REM_W       = 61;   // root remainder with two shifted-in bits
  localparam int NUM_W       = 106;  // slope numerator
  localparam int DVS_W       = 60;   // slope divisor
  localparam int QUO_W       = 48;   // quotient bits produced
  localparam int DIV_STAGES  = 48;   // one quotient bit per stage
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 432;

  localparam logic [CFG_IDX_W-1:0] REG_AXIAL_FIELD    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIAL_GRADIENT = 1'b1;

  localparam logic [REG_W-1:0] SAT_MAX = {1'b0, {(REG_W-1){1'b1}}};
  localparam logic [REG_W-1:0] SAT_MIN = {1'b1, {(REG_W-1){1'b0}}};

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [REG_W-1:0] b0;    // axial field, two's complement
    logic [REG_W-1:0] gm;    // |gradient|
    logic             gneg;  // gradient is negative
  } cfg_t;

  // Rounded, unsaturated field components (two's complement), x at index 0
  typedef struct packed {
    logic [2:0][C_W-1:0] c;
  } comp_t;

  typedef struct packed {
    logic [2:0][REG_W-1:0] fld;
    logic [MAG_W-1:0]      mag;
    logic [2:0][REG_W-1:0] slope;
    logic                  zero;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/gfm_front.sv =====
// Front pipeline: accepts positions and forms the rounded field components.
// Depends on gfm_pkg; feeds gfm_queue.
`default_nettype none

module gfm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0][gfm_pkg::POS_W-1:0]      pos,
  input  gfm_pkg::cfg_t                       cfg,
  output logic                                push,
  input  logic                                q_full,
  output gfm_pkg::comp_t                      comp
);
  import gfm_pkg::*;

  logic [3:0]               v_r;
  logic                     fe;
  logic [2:0][POS_W-1:0]    a0_r;
  logic [2:0]               n0_r, n1_r, n2_r;
  logic [2:0][CM_W-1:0]     pl1_r, ph1_r;
  logic [2:0][CM_W-1:0]     m2_r;
  comp_t                    comp_r;

  logic [2:0][POS_W-1:0]    a0_nxt;
  logic [2:0]               n0_nxt;
  logic [2:0][CM_W-1:0]     pl1_nxt, ph1_nxt, m2_nxt;
  comp_t                    comp_nxt;

  assign fe       = !(v_r[3] && q_full);
  assign in_ready = fe;
  assign push     = v_r[3] && !q_full;
  assign comp     = comp_r;

  always_comb begin
    logic [80:0]  acc;
    logic [C_W-1:0] ms;
    logic [C_W-1:0] sv;
    for (int i = 0; i < 3; i++) begin
      a0_nxt[i] = pos[i][POS_W-1] ? (~pos[i] + POS_W'(1)) : pos[i];
      // component is -k*p*g, so x and y flip the product sign, z keeps it
      n0_nxt[i] = (i < 2) ? (pos[i][POS_W-1] == cfg.gneg) : (pos[i][POS_W-1] != cfg.gneg);
      pl1_nxt[i] = CM_W'(a0_r[i]) * CM_W'(cfg.gm[23:0]);
      ph1_nxt[i] = CM_W'(a0_r[i]) * CM_W'(cfg.gm[REG_W-1:24]);
      if (i < 2) begin
        acc = {1'b0, ph1_r[i], 24'b0} + 81'(pl1_r[i]) + (81'(1) << 24);
        m2_nxt[i] = CM_W'(acc >> 25);
      end else begin
        acc = {1'b0, ph1_r[i], 24'b0} + 81'(pl1_r[i]) + (81'(1) << 23);
        m2_nxt[i] = CM_W'(acc >> 24);
      end
      ms = {1'b0, m2_r[i]};
      sv = n2_r[i] ? (~ms + C_W'(1)) : ms;
      if (i == 2) begin
        comp_nxt.c[i] = sv + {{(C_W-REG_W){cfg.b0[REG_W-1]}}, cfg.b0};
      end else begin
        comp_nxt.c[i] = sv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (fe) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      a0_r   <= a0_nxt;
      n0_r   <= n0_nxt;
      pl1_r  <= pl1_nxt;
      ph1_r  <= ph1_nxt;
      n1_r   <= n0_r;
      m2_r   <= m2_nxt;
      n2_r   <= n1_r;
      comp_r <= comp_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gfm_queue.sv =====
// Short queue of field components between the front and back pipelines.
// Depends on gfm_pkg.
`default_nettype none

module gfm_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gfm_pkg::comp_t din,
  output logic           full,
  input  logic           pop,
  output gfm_pkg::comp_t dout,
  output logic           not_empty
);
  import gfm_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  comp_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gfm_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on gfm_pkg; used by gfm_back.
`default_nettype none

module gfm_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [gfm_pkg::RAD_W-1:0]  rad,
  output logic [gfm_pkg::ROOT_W-1:0] root
);
  import gfm_pkg::*;

  logic [REM_W-1:0]  rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_r  [SQRT_STAGES];

  assign root = root_r[SQRT_STAGES-1];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rad_in  = rad_r[j-1];
    end

    // bring down the next pair of radicand bits and try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[2*(SQRT_STAGES-1-j) +: 2]};
    assign trial  = REM_W'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[j] <= {root_in[ROOT_W-2:0], ge};
        rad_r[j]  <= rad_in;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gfm_div.sv =====
// Pipelined restoring divider with overflow detection, one quotient bit per stage.
// Depends on gfm_pkg; used by gfm_back for each magnitude slope.
`default_nettype none

module gfm_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [gfm_pkg::NUM_W-1:0] num,
  input  logic [gfm_pkg::DVS_W-1:0] dvs,
  output logic [gfm_pkg::QUO_W-1:0] quo,
  output logic                      ovf
);
  import gfm_pkg::*;

  localparam int HI_W = NUM_W - QUO_W;

  logic [DVS_W-1:0] rem_r [DIV_STAGES+1];
  logic [DVS_W-1:0] dvs_r [DIV_STAGES+1];
  logic [QUO_W-1:0] low_r [DIV_STAGES+1];
  logic [QUO_W-1:0] q_r   [DIV_STAGES+1];
  logic             ovf_r [DIV_STAGES+1];

  logic             ovf0;

  assign quo  = q_r[DIV_STAGES];
  assign ovf  = ovf_r[DIV_STAGES];
  // quotient would need more than QUO_W bits
  assign ovf0 = (DVS_W'(num[NUM_W-1:QUO_W]) >= dvs);

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= ovf0;
      rem_r[0] <= ovf0 ? '0 : DVS_W'(num[NUM_W-1:QUO_W]);
      dvs_r[0] <= dvs;
      low_r[0] <= num[QUO_W-1:0];
      q_r[0]   <= '0;
    end
  end

  for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_stage
    logic [DVS_W:0] trial;
    logic           ge;

    assign trial = {rem_r[i-1], low_r[i-1][QUO_W-i]};
    assign ge    = (trial >= {1'b0, dvs_r[i-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? DVS_W'(trial - {1'b0, dvs_r[i-1]}) : DVS_W'(trial);
        q_r[i]   <= {q_r[i-1][QUO_W-2:0], ge};
        dvs_r[i] <= dvs_r[i-1];
        low_r[i] <= low_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gfm_back.sv =====
// Back pipeline: squares, root, magnitude slopes, saturation, output register.
// Depends on gfm_pkg, gfm_sqrt and gfm_div.
`default_nettype none

module gfm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  gfm_pkg::cfg_t    cfg,
  input  logic             q_not_empty,
  input  gfm_pkg::comp_t   q_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output gfm_pkg::result_t res
);
  import gfm_pkg::*;

  typedef struct packed {
    logic [2:0][CM_W-1:0]  cm;
    logic [2:0]            cneg;
    logic [2:0][REG_W-1:0] fld;
  } mid_t;

  typedef struct packed {
    logic [2:0][REG_W-1:0] fld;
    logic [MAG_W-1:0]      mag;
    logic                  zero;
    logic [2:0]            sneg;
  } tail_t;

  localparam int MID_LEN  = 5 + SQRT_STAGES;
  localparam int TAIL_LEN = 3 + DIV_STAGES + 1;
  localparam int VLD_LEN  = MID_LEN + TAIL_LEN + 1;
  localparam int PP_W     = 52;
  localparam int P_W      = 104;

  logic                 be;
  logic [VLD_LEN-1:0]   vld_r;
  mid_t                 mid_r  [MID_LEN];
  tail_t                tail_r [TAIL_LEN];

  mid_t                 mid_nxt;
  logic [2:0][CM_W-1:0] hh_r, hl_r, ll_r;
  logic [2:0][SQ_W-1:0] sq_r;
  logic [RAD_W-1:0]     sxy_r, sum_r;
  logic [SQ_W-1:0]      sqz_r;
  logic [ROOT_W-1:0]    root;

  logic [2:0][3:0][PP_W-1:0] pp_r;
  logic [ROOT_W-1:0]    root0_r, root1_r;
  logic [2:0][P_W-1:0]  p_r;
  logic [2:0][NUM_W-1:0] num_r;
  logic [2:0][DVS_W-1:0] dvs_r;
  tail_t                tail_nxt;
  logic [2:0][QUO_W-1:0] quo;
  logic [2:0]           ovf;
  result_t              res_r, res_nxt;

  assign be        = !vld_r[VLD_LEN-1] || out_ready;
  assign pop       = be && q_not_empty;
  assign out_valid = vld_r[VLD_LEN-1];
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (be) begin
      vld_r <= {vld_r[VLD_LEN-2:0], q_not_empty};
    end
  end

  // component magnitude, sign and saturated field value
  always_comb begin
    logic [C_W-1:0] c;
    for (int i = 0; i < 3; i++) begin
      c = q_data.c[i];
      mid_nxt.cneg[i] = c[C_W-1];
      mid_nxt.cm[i]   = c[C_W-1] ? CM_W'(~c + C_W'(1)) : CM_W'(c);
      if (!c[C_W-1] && (|c[C_W-2:REG_W-1])) begin
        mid_nxt.fld[i] = SAT_MAX;
      end else if (c[C_W-1] && !(&c[C_W-2:REG_W-1])) begin
        mid_nxt.fld[i] = SAT_MIN;
      end else begin
        mid_nxt.fld[i] = c[REG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      mid_r[0] <= mid_nxt;
      for (int k = 1; k < MID_LEN; k++) begin
        mid_r[k] <= mid_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= CM_W'(mid_r[0].cm[i][CM_W-1:28]) * CM_W'(mid_r[0].cm[i][CM_W-1:28]);
        hl_r[i] <= CM_W'(mid_r[0].cm[i][CM_W-1:28]) * CM_W'(mid_r[0].cm[i][27:0]);
        ll_r[i] <= CM_W'(mid_r[0].cm[i][27:0]) * CM_W'(mid_r[0].cm[i][27:0]);
        sq_r[i] <= {hh_r[i], 56'b0} + SQ_W'({hl_r[i], 29'b0}) + SQ_W'(ll_r[i]);
      end
      sxy_r <= RAD_W'(sq_r[0]) + RAD_W'(sq_r[1]);
      sqz_r <= sq_r[2];
      sum_r <= sxy_r + RAD_W'(sqz_r);
    end
  end

  gfm_sqrt u_sqrt (
    .clk  (clk),
    .en   (be),
    .rad  (sum_r),
    .root (root)
  );

  // root stage: magnitude, zero flag and slope signs
  always_comb begin
    mid_t m;
    m = mid_r[MID_LEN-1];
    tail_nxt.fld  = m.fld;
    tail_nxt.zero = (root == '0);
    tail_nxt.mag  = (|root[ROOT_W-1:MAG_W]) ? {MAG_W{1'b1}} : root[MAG_W-1:0];
    tail_nxt.sneg[0] = m.cneg[0] != !cfg.gneg;
    tail_nxt.sneg[1] = m.cneg[1] != !cfg.gneg;
    tail_nxt.sneg[2] = m.cneg[2] != cfg.gneg;
  end

  always_ff @(posedge clk) begin
    if (be) begin
      tail_r[0] <= tail_nxt;
      for (int k = 1; k < TAIL_LEN; k++) begin
        tail_r[k] <= tail_r[k-1];
      end
      root0_r <= root;
      root1_r <= root0_r;
      for (int i = 0; i < 3; i++) begin
        pp_r[i][0] <= PP_W'(mid_r[MID_LEN-1].cm[i][27:0]) * PP_W'(cfg.gm[23:0]);
        pp_r[i][1] <= PP_W'(mid_r[MID_LEN-1].cm[i][27:0]) * PP_W'(cfg.gm[REG_W-1:24]);
        pp_r[i][2] <= PP_W'(mid_r[MID_LEN-1].cm[i][CM_W-1:28]) * PP_W'(cfg.gm[23:0]);
        pp_r[i][3] <= PP_W'(mid_r[MID_LEN-1].cm[i][CM_W-1:28]) * PP_W'(cfg.gm[REG_W-1:24]);
        p_r[i] <= P_W'(pp_r[i][0]) + P_W'({pp_r[i][1], 24'b0})
                + P_W'({pp_r[i][2], 28'b0}) + {pp_r[i][3], 52'b0};
        // slope = round(cm*g/den): (2*cm*g + den) / (2*den)
        if (i < 2) begin
          num_r[i] <= {1'b0, p_r[i], 1'b0} + NUM_W'({root1_r, 1'b0});
          dvs_r[i] <= DVS_W'({root1_r, 2'b00});
        end else begin
          num_r[i] <= {1'b0, p_r[i], 1'b0} + NUM_W'(root1_r);
          dvs_r[i] <= DVS_W'({root1_r, 1'b0});
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    gfm_div u_div (
      .clk (clk),
      .en  (be),
      .num (num_r[i]),
      .dvs (dvs_r[i]),
      .quo (quo[i]),
      .ovf (ovf[i])
    );
  end

  always_comb begin
    tail_t t;
    t = tail_r[TAIL_LEN-1];
    res_nxt.fld  = t.fld;
    res_nxt.mag  = t.zero ? '0 : t.mag;
    res_nxt.zero = t.zero;
    for (int i = 0; i < 3; i++) begin
      if (t.zero) begin
        res_nxt.slope[i] = '0;
      end else if (ovf[i] || quo[i][QUO_W-1]) begin
        res_nxt.slope[i] = t.sneg[i] ? SAT_MIN : SAT_MAX;
      end else if (t.sneg[i]) begin
        res_nxt.slope[i] = ~quo[i] + REG_W'(1);
      end else begin
        res_nxt.slope[i] = quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gradient_field_magnitude_eval_core.sv =====
// Gradient field magnitude evaluator, top level.
// Depends on gfm_pkg, gfm_front, gfm_queue and gfm_back.
`default_nettype none

// Evaluates the field of an axial field b0 with axial gradient g at each
// position (x, y, z): B = (-x*g/2, -y*g/2, b0 + g*z), the constant slopes
// -g/2 and g, |B| and the three partial derivatives of |B|, all saturated to
// their field widths. Positions are Q8.24 metres, fields 2^-48 tesla. Every
// input transaction gives exactly one output transaction, in order. The core
// takes one position per clock cycle while its queue has room; most of the
// pipeline depth lies in the bit-per-stage square root (57 stages) and the
// bit-per-stage slope dividers (49 stages). The front pipeline forms the rounded
// field components and parks them in a small queue (QUEUE_DEPTH entries), so
// the front keeps accepting while the back pipeline waits on out_tready.
// Write axial_field (index 0) and axial_gradient (index 1) only while no
// transaction is in flight; both reset to zero.
module gradient_field_magnitude_eval_core #(
  parameter int QUEUE_DEPTH = 4   // 2 or more
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [gfm_pkg::IN_TDATA_W-1:0]       in_tdata,
  // out_tdata: field_x [47:0], field_y [95:48], field_z [143:96],
  //   transverse_slope [191:144], axial_slope [239:192],
  //   field_magnitude [286:240], mag_slope_x [334:287],
  //   mag_slope_y [382:335], mag_slope_z [430:383], zero pad [431]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [gfm_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: zero_magnitude [0]
  output logic                                 out_tuser,
  input  logic                                 cfg_we,
  input  logic [gfm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gfm_pkg::REG_W-1:0]            cfg_wdata
);
  import gfm_pkg::*;

  logic [REG_W-1:0]      axial_field_r, axial_gradient_r;
  cfg_t                  cfg;
  logic [REG_W-1:0]      half_g, trans_slope;
  logic [2:0][POS_W-1:0] pos;
  logic                  push, q_full, q_not_empty, pop;
  comp_t                 comp_in, comp_out;
  result_t               res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axial_field_r    <= '0;
      axial_gradient_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AXIAL_FIELD:    axial_field_r    <= cfg_wdata;
        REG_AXIAL_GRADIENT: axial_gradient_r <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  assign cfg.b0   = axial_field_r;
  assign cfg.gneg = axial_gradient_r[REG_W-1];
  assign cfg.gm   = axial_gradient_r[REG_W-1] ? (~axial_gradient_r + REG_W'(1))
                                              : axial_gradient_r;

  // -g/2 rounded half away from zero; |g|/2 never needs saturation
  assign half_g      = (cfg.gm + REG_W'(1)) >> 1;
  assign trans_slope = cfg.gneg ? half_g : (~half_g + REG_W'(1));

  assign pos[0] = in_tdata[31:0];
  assign pos[1] = in_tdata[63:32];
  assign pos[2] = in_tdata[95:64];

  gfm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .pos      (pos),
    .cfg      (cfg),
    .push     (push),
    .q_full   (q_full),
    .comp     (comp_in)
  );

  gfm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (comp_in),
    .full      (q_full),
    .pop       (pop),
    .dout      (comp_out),
    .not_empty (q_not_empty)
  );

  gfm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_data      (comp_out),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .res         (res)
  );

  // slopes depend only on the gradient, which the user must hold stable while busy; the block does not enforce this
  assign out_tdata = {1'b0, res.slope[2], res.slope[1], res.slope[0], res.mag,
                      axial_gradient_r, trans_slope,
                      res.fld[2], res.fld[1], res.fld[0]};
  assign out_tuser = res.zero;

`ifndef NO_ASSERTIONS
  // zero flag is raised exactly when the magnitude is zero
  a_zero_iff_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[286:240] == '0)))
    else $error("zero flag disagrees with magnitude");

  // a zero magnitude forces all three magnitude slopes to zero
  a_zero_slopes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[430:287] == '0))
    else $error("nonzero slope with zero magnitude");

  // the front never writes a full queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !pop |=> !push || !q_full || pop)
    else $error("queue overrun");
`endif

endmodule

`default_nettype wire

// ===== verif/gradient_field_magnitude_eval_core_test.sv =====
// Self-checking testbench for gradient_field_magnitude_eval_core.
// Uses gfm_pkg for widths and register indexes; predicts each result in place
// and checks the output stream against it, with random stalls on both sides.
`timescale 1ns / 1ps

module gradient_field_magnitude_eval_core_test;
  import gfm_pkg::*;

  localparam int RUN_LIMIT  = 400000;  // cycles
  localparam int DRAIN_WAIT = 160;     // settle time after the last expected result, longer than the pipeline latency
  localparam int LONG_HOLD  = 400;     // receiver hold-off while the sender keeps going

  localparam logic signed [127:0] S48_MAX = 128'sh7FFF_FFFF_FFFF;
  localparam logic signed [127:0] S48_MIN = -(128'sh8000_0000_0000);

  // Expected output transaction: data as packed on out_tdata, flag as on out_tuser
  typedef struct {
    logic [OUT_TDATA_W-1:0] data;
    logic                   zero;
  } field_result_t;

  // Round p / 2^sh to nearest, halves away from zero
  function automatic logic signed [127:0] round_shift(logic signed [127:0] p, int sh);
    logic signed [127:0] m;
    m = ((p < 0 ? -p : p) + (128'sd1 <<< (sh - 1))) >>> sh;
    return p < 0 ? -m : m;
  endfunction

  function automatic logic [REG_W-1:0] clamp48(logic signed [127:0] v);
    if (v > S48_MAX) return SAT_MAX;
    if (v < S48_MIN) return SAT_MIN;
    return v[REG_W-1:0];
  endfunction

  // round(cm*gm/(k*root)), halves away from zero, signed and clamped
  function automatic logic [REG_W-1:0] mag_deriv(logic signed [127:0] cm,
                                                 logic signed [127:0] gm, int k,
                                                 logic signed [127:0] root, bit neg);
    logic signed [127:0] q;
    q = (2 * cm * gm + k * root) / (2 * k * root);
    return clamp48(neg ? -q : q);
  endfunction

  // Scoreboard: keeps the register copy and the queue of expected results.
  class field_scoreboard;
    logic signed [REG_W-1:0] b0;
    logic signed [REG_W-1:0] grad;
    field_result_t           pending[$];
    int                      errors;
    int                      results;
    int                      zero_hits;

    function new();
      b0 = '0;
      grad = '0;
      errors = 0;
      results = 0;
      zero_hits = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      if (idx == REG_AXIAL_FIELD) b0 = val;
      else if (idx == REG_AXIAL_GRADIENT) grad = val;
    endfunction

    // Work out the expected result of one accepted position
    function void note_position(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                                logic signed [POS_W-1:0] pz);
      logic signed [127:0] x, y, z, g, gm, cx, cy, cz, sum, root, cand, h;
      field_result_t r;
      x = px;
      y = py;
      z = pz;
      g = grad;
      gm = g < 0 ? -g : g;
      cx = -round_shift(x * g, 25);
      cy = -round_shift(y * g, 25);
      cz = 128'(b0) + round_shift(z * g, 24);
      h = (gm + 1) >>> 1;
      r.data = '0;
      r.data[47:0]    = clamp48(cx);
      r.data[95:48]   = clamp48(cy);
      r.data[143:96]  = clamp48(cz);
      r.data[191:144] = clamp48(g < 0 ? h : -h);
      r.data[239:192] = grad;
      sum = cx * cx + cy * cy + cz * cz;
      r.zero = (sum == 0);
      if (sum != 0) begin
        root = 0;
        for (int b = 56; b >= 0; b--) begin
          cand = root | (128'sd1 <<< b);
          if (cand * cand <= sum) root = cand;
        end
        r.data[286:240] = root > S48_MAX ? SAT_MAX[MAG_W-1:0] : root[MAG_W-1:0];
        r.data[334:287] = mag_deriv(cx < 0 ? -cx : cx, gm, 2, root, (cx < 0) != (g >= 0));
        r.data[382:335] = mag_deriv(cy < 0 ? -cy : cy, gm, 2, root, (cy < 0) != (g >= 0));
        r.data[430:383] = mag_deriv(cz < 0 ? -cz : cz, gm, 1, root, (cz < 0) != (g < 0));
      end
      pending.push_back(r);
    endfunction

    task report(string what, logic [REG_W-1:0] got, logic [REG_W-1:0] want);
      $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] data, logic zero);
      string names[9] = '{"field_x", "field_y", "field_z", "transverse_slope",
                          "axial_slope", "field_magnitude", "mag_slope_x",
                          "mag_slope_y", "mag_slope_z"};
      field_result_t want;
      int lo;
      int w;
      logic [REG_W-1:0] a, e;
      results++;
      if (pending.size() == 0) begin
        report("unexpected transaction", data[REG_W-1:0], '0);
      end else begin
        want = pending.pop_front();
        if (want.zero) zero_hits++;
        lo = 0;
        for (int i = 0; i < 9; i++) begin
          w = (i == 5) ? MAG_W : REG_W;
          a = REG_W'((data >> lo) & ((OUT_TDATA_W'(1) << w) - OUT_TDATA_W'(1)));
          e = REG_W'((want.data >> lo) & ((OUT_TDATA_W'(1) << w) - OUT_TDATA_W'(1)));
          if (a !== e) report(names[i], a, e);
          lo += w;
        end
        if (zero !== want.zero) report("zero_magnitude", 48'(zero), 48'(want.zero));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_AXIAL_FIELD;
  logic [REG_W-1:0]       cfg_wdata = '0;

  field_scoreboard sb = new();
  int  cycle_count = 0;
  int  positions_sent = 0;
  bit  hold_request = 0;   // main flow asks the receiver for one long hold-off
  int  hold_left = 0;

  gradient_field_magnitude_eval_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               sb.pending.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random backpressure, occasional short stalls, one long hold-off on request
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_request = 0;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) hold_left <= $urandom_range(20, 60);
      // long runs of full throughput in between
      out_tready <= (cycle_count % 1000 < 300) ? 1'b1 : (r >= 25);
    end
  end

  // Result checker: one transaction per handshake edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Stop offering, wait until every expected result is back, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Offer one position; gap cycles of idle come first
  task automatic send_position(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                               logic [POS_W-1:0] z, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_position(x, y, z);
    positions_sent++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [POS_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return $urandom;
      4, 5: return POS_W'($signed($urandom_range(0, 65535)) - 32768);
      6: return {1'b0, {(POS_W-1){1'b1}}};
      7: return {1'b1, {(POS_W-1){1'b0}}};
      8: return '0;
      default: return POS_W'($signed($urandom_range(0, 7)) - 4) <<< $urandom_range(0, 28);
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_reg();
    int r;
    r = $urandom_range(0, 4);
    case (r)
      0, 1: return REG_W'({$urandom, $urandom});
      2: return REG_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) <<< $urandom_range(0, 26);
      3: return SAT_MAX;
      default: return SAT_MIN;
    endcase
  endfunction

  // Extremes, the origin (zero magnitude when b0 is zero) and unit steps
  task automatic directed_positions();
    logic [POS_W-1:0] pmax, pmin;
    pmax = {1'b0, {(POS_W-1){1'b1}}};
    pmin = {1'b1, {(POS_W-1){1'b0}}};
    send_position('0, '0, '0, 0);
    send_position(pmax, pmax, pmax, 0);
    send_position(pmin, pmin, pmin, 1);
    send_position(pmin, pmax, '0, 0);
    send_position(32'd1, -32'sd1, 32'd1, 2);
    send_position(-32'sd1, 32'd1, -32'sd1, 0);
    send_position(32'h0100_0000, '0, -32'sh0100_0000, 0);
    send_position('0, '0, 32'd1, 3);
  endtask

  task automatic random_positions(int count);
    repeat (count) send_position(pick_coord(), pick_coord(), pick_coord(), pick_gap());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: everything zero, every position gives zero magnitude
    directed_positions();
    random_positions(10);
    drain();

    // Both registers at their maximum, then both registers at their minimum
    write_reg(REG_AXIAL_FIELD, SAT_MAX);
    write_reg(REG_AXIAL_GRADIENT, SAT_MAX);
    directed_positions();
    random_positions(40);
    drain();

    write_reg(REG_AXIAL_FIELD, SAT_MIN);
    write_reg(REG_AXIAL_GRADIENT, SAT_MIN);
    directed_positions();
    random_positions(40);
    drain();

    // b0 zero with a live gradient: the origin is a zero-magnitude point.
    // Receiver holds off long while the sender streams more than the core
    // holds, so the core backs up and stalls its input.
    write_reg(REG_AXIAL_FIELD, '0);
    write_reg(REG_AXIAL_GRADIENT, pick_reg());
    directed_positions();
    hold_request = 1;
    repeat (160) send_position(pick_coord(), pick_coord(), pick_coord(), 0);
    drain();

    // Several random settings
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_AXIAL_FIELD, pick_reg());
      write_reg(REG_AXIAL_GRADIENT, pick_reg());
      random_positions(25);
      drain();
    end

    write_reg(REG_AXIAL_FIELD, SAT_MIN);
    write_reg(REG_AXIAL_GRADIENT, SAT_MAX);
    random_positions(30);
    in_tvalid <= 1'b0;
    drain();

    $display("covered %0d positions over 11 register settings, %0d results checked",
             positions_sent, sb.results);
    $display("%0d zero-magnitude results, long receiver hold-off exercised", sb.zero_hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gfm_pkg.sv
rtl/gfm_front.sv
rtl/gfm_queue.sv
rtl/gfm_sqrt.sv
rtl/gfm_div.sv
rtl/gfm_back.sv
rtl/gradient_field_magnitude_eval_core.sv
verif/gradient_field_magnitude_eval_core_test.sv
